/* hdl/gcsa_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and step functions for the gravity-corrected scatter angle pipeline.
// No dependencies; used by gravity_corrected_scatter_angle.
package gcsa_pkg;

    typedef enum logic [2:0] {
        REG_LOS_X      = 3'd0,
        REG_LOS_Y      = 3'd1,
        REG_LOS_Z      = 3'd2,
        REG_BEAM_X     = 3'd3,
        REG_BEAM_Y     = 3'd4,
        REG_BEAM_Z     = 3'd5,
        REG_BEAM_NORM  = 3'd6,
        REG_DROP_COEFF = 3'd7
    } t_reg_idx;

    localparam int SQ_STEPS   = 32;
    localparam int DIV_STEPS  = 32;
    localparam int FRAC_STEPS = 17;
    localparam int RS_STEPS   = 17;

    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
    localparam logic [32:0]        RAD_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic [31:0] mx;
        logic [31:0] my;
        logic        nx;
        logic        ny;
        logic        inv;
    } t_side;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [63:0] num;
        logic [31:0] q;
    } t_dv;

    typedef struct packed {
        logic [31:0] rem;
        logic [16:0] q;
    } t_fd;

    function automatic logic [31:0] mag34(logic signed [33:0] v);
        logic [33:0] a;
        a = v[33] ? 34'(-v) : 34'(v);
        return a[31:0];
    endfunction

    // one radicand digit pair per call
    function automatic t_sq sqrt_step(t_sq s, logic [1:0] b);
        t_sq         o;
        logic [36:0] cur;
        logic [36:0] trial;
        cur   = {s.rem, b};
        trial = {3'b000, s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = 35'(cur - trial);
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = cur[34:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv div_step(t_dv s, logic [63:0] den);
        t_dv         o;
        logic [64:0] full;
        full = {s.num, 1'b0};
        if (full >= {1'b0, den}) begin
            o.num = 64'(full - {1'b0, den});
            o.q   = {s.q[30:0], 1'b1};
        end else begin
            o.num = full[63:0];
            o.q   = {s.q[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_fd frac_step(t_fd s, logic b, logic [31:0] d);
        t_fd         o;
        logic [32:0] cur;
        cur = {s.rem, b};
        if (cur >= {1'b0, d}) begin
            o.rem = 32'(cur - {1'b0, d});
            o.q   = {s.q[15:0], 1'b1};
        end else begin
            o.rem = cur[31:0];
            o.q   = {s.q[15:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* hdl/gravity_corrected_scatter_angle.sv */
`timescale 1ns / 1ps
// Top level: gravity-corrected scattering angle and azimuth cosines, fully pipelined.
// Depends on gcsa_pkg.
//
// One wavelength enters every cycle (busy is always low). o_valid rises as each result leaves
// the output register, in request order. The stages are five front stages,
// the 32-step length and in-plane radius square roots side by side, a product stage, the
// 32-step radicand divider with the azimuth divides alongside, and the 17-step final root.
// Each root and divider section has a load stage, and an output register ends the pipeline.
// Results cannot be held off. Write configuration only while no request is in flight.
module gravity_corrected_scatter_angle
    import gcsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_wavelength,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic [16:0]        o_sin_theta,
    output logic signed [17:0] o_x_fraction,
    output logic signed [17:0] o_y_fraction,
    output logic               o_invalid
);

    localparam int LAT = 6 + SQ_STEPS + 2 + DIV_STEPS + 1 + RS_STEPS + 1;

    logic signed [31:0] r_los_x, r_los_y, r_los_z;
    logic signed [31:0] r_beam_x, r_beam_y, r_beam_z;
    logic [30:0]        r_beam_norm;
    logic [31:0]        r_drop_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_los_x      <= '0;
            r_los_y      <= '0;
            r_los_z      <= '0;
            r_beam_x     <= '0;
            r_beam_y     <= '0;
            r_beam_z     <= 32'sd1048576;
            r_beam_norm  <= 31'd2097152;
            r_drop_coeff <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_LOS_X:      r_los_x      <= i_cfg_data;
                REG_LOS_Y:      r_los_y      <= i_cfg_data;
                REG_LOS_Z:      r_los_z      <= i_cfg_data;
                REG_BEAM_X:     r_beam_x     <= i_cfg_data;
                REG_BEAM_Y:     r_beam_y     <= i_cfg_data;
                REG_BEAM_Z:     r_beam_z     <= i_cfg_data;
                REG_BEAM_NORM:  r_beam_norm  <= i_cfg_data[30:0];
                REG_DROP_COEFF: r_drop_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // front stages: A input, B square, C drop product, D corrected vector, E products
    logic        r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic [15:0] r_a_w;
    logic [31:0] r_b_wsq;
    logic [63:0] r_c_prod;
    logic signed [31:0] r_d_lx, r_d_lz;
    logic signed [33:0] r_d_ly;
    logic [63:0] r_e_sqx, r_e_sqy, r_e_sqz, r_e_px, r_e_py, r_e_pz;
    logic [2:0]  r_e_sgn;
    t_side       r_e_side;

    logic [28:0]        n_drop;
    logic signed [33:0] n_ly;
    logic [31:0]        n_mx, n_my, n_mz, n_bx, n_by, n_bz;

    always_comb begin
        n_drop = 29'((30'(r_c_prod[63:35]) + 30'd1) >> 1);
        n_ly   = 34'(r_los_y) + 34'(signed'({5'b00000, n_drop}));
        n_mx   = mag34(34'(r_d_lx));
        n_my   = mag34(r_d_ly);
        n_mz   = mag34(34'(r_d_lz));
        n_bx   = mag34(34'(r_beam_x));
        n_by   = mag34(34'(r_beam_y));
        n_bz   = mag34(34'(r_beam_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_a_v <= start && !busy;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_w    <= i_wavelength;
        r_b_wsq  <= 32'(r_a_w) * 32'(r_a_w);
        r_c_prod <= 64'(r_drop_coeff) * 64'(r_b_wsq);
        r_d_lx   <= r_los_x;
        r_d_ly   <= n_ly;
        r_d_lz   <= r_los_z;
        r_e_sqx  <= 64'(n_mx) * 64'(n_mx);
        r_e_sqy  <= 64'(n_my) * 64'(n_my);
        r_e_sqz  <= 64'(n_mz) * 64'(n_mz);
        r_e_px   <= 64'(n_mx) * 64'(n_bx);
        r_e_py   <= 64'(n_my) * 64'(n_by);
        r_e_pz   <= 64'(n_mz) * 64'(n_bz);
        r_e_sgn  <= {r_d_lz[31] ^ r_beam_z[31], r_d_ly[33] ^ r_beam_y[31],
                     r_d_lx[31] ^ r_beam_x[31]};
        r_e_side <= '{mx: n_mx, my: n_my, nx: r_d_lx[31], ny: r_d_ly[33],
                      inv: (r_d_lx == 0) && (r_d_ly == 0) && (r_d_lz == 0)};
    end

    // F stage is index 0 of the square root section
    logic               r_sq_v    [0:SQ_STEPS];
    logic [63:0]        r_sq_len  [0:SQ_STEPS];
    logic [63:0]        r_sq_rr2  [0:SQ_STEPS];
    t_sq                r_sq_n    [0:SQ_STEPS];
    t_sq                r_sq_r    [0:SQ_STEPS];
    logic signed [65:0] r_sq_dot  [0:SQ_STEPS];
    t_side              r_sq_side [0:SQ_STEPS];

    logic signed [65:0] n_tx, n_ty, n_tz;

    always_comb begin
        n_tx = r_e_sgn[0] ? -66'(r_e_px) : 66'(r_e_px);
        n_ty = r_e_sgn[1] ? -66'(r_e_py) : 66'(r_e_py);
        n_tz = r_e_sgn[2] ? -66'(r_e_pz) : 66'(r_e_pz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_len[0]  <= r_e_sqx + r_e_sqy + r_e_sqz;
        r_sq_rr2[0]  <= r_e_sqx + r_e_sqy;
        r_sq_n[0]    <= '0;
        r_sq_r[0]    <= '0;
        r_sq_dot[0]  <= n_tx + n_ty + n_tz;
        r_sq_side[0] <= r_e_side;
    end

    genvar k;
    for (k = 1; k <= SQ_STEPS; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            r_sq_n[k]    <= sqrt_step(r_sq_n[k-1], r_sq_len[k-1][63:62]);
            r_sq_r[k]    <= sqrt_step(r_sq_r[k-1], r_sq_rr2[k-1][63:62]);
            r_sq_len[k]  <= {r_sq_len[k-1][61:0], 2'b00};
            r_sq_rr2[k]  <= {r_sq_rr2[k-1][61:0], 2'b00};
            r_sq_dot[k]  <= r_sq_dot[k-1];
            r_sq_side[k] <= r_sq_side[k-1];
        end
    end

    // M stage: length times beam norm, dot magnitude
    logic        r_m_v;
    logic [62:0] r_m_nb;
    logic [63:0] r_m_dabs;
    logic        r_m_dneg;
    logic [31:0] r_m_rr;
    t_side       r_m_side;

    logic [30:0] n_bn;
    logic [65:0] n_dabs;

    always_comb begin
        n_bn   = (r_beam_norm == '0) ? 31'd1 : r_beam_norm;
        n_dabs = r_sq_dot[SQ_STEPS][65] ? 66'(-r_sq_dot[SQ_STEPS])
                                        : 66'(r_sq_dot[SQ_STEPS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_nb   <= 63'(r_sq_n[SQ_STEPS].root) * 63'(n_bn);
        r_m_dabs <= n_dabs[63:0];
        r_m_dneg <= r_sq_dot[SQ_STEPS][65];
        r_m_rr   <= r_sq_r[SQ_STEPS].root;
        r_m_side <= r_sq_side[SQ_STEPS];
    end

    // N stage is index 0 of the divider section; azimuth divides run alongside
    logic        r_dv_v    [0:DIV_STEPS];
    t_dv         r_dv      [0:DIV_STEPS];
    logic [63:0] r_dv_den  [0:DIV_STEPS];
    logic        r_dv_sat  [0:DIV_STEPS];
    logic        r_dv_dneg [0:DIV_STEPS];
    logic [31:0] r_dv_rr   [0:DIV_STEPS];
    t_fd         r_dv_fx   [0:DIV_STEPS];
    t_fd         r_dv_fy   [0:DIV_STEPS];
    t_side       r_dv_side [0:DIV_STEPS];

    logic [63:0] n_num;
    logic        n_sat;

    always_comb begin
        n_sat = r_m_dabs[63] || ({r_m_dabs, 1'b0} >= {2'b00, r_m_nb});
        if (r_m_dneg) begin
            n_num = {1'b0, r_m_nb} + {r_m_dabs[62:0], 1'b0};
        end else begin
            n_num = {1'b0, r_m_nb} - {r_m_dabs[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv[0]      <= '{num: n_num, q: '0};
        r_dv_den[0]  <= {r_m_nb, 1'b0};
        r_dv_sat[0]  <= n_sat;
        r_dv_dneg[0] <= r_m_dneg;
        r_dv_rr[0]   <= r_m_rr;
        r_dv_fx[0]   <= '{rem: {1'b0, r_m_side.mx[31:1]}, q: '0};
        r_dv_fy[0]   <= '{rem: {1'b0, r_m_side.my[31:1]}, q: '0};
        r_dv_side[0] <= r_m_side;
    end

    for (k = 1; k <= DIV_STEPS; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            r_dv[k]      <= div_step(r_dv[k-1], r_dv_den[k-1]);
            r_dv_den[k]  <= r_dv_den[k-1];
            r_dv_sat[k]  <= r_dv_sat[k-1];
            r_dv_dneg[k] <= r_dv_dneg[k-1];
            r_dv_rr[k]   <= r_dv_rr[k-1];
            r_dv_side[k] <= r_dv_side[k-1];
        end
        if (k <= FRAC_STEPS) begin : g_fr
            always_ff @(posedge i_clk) begin
                r_dv_fx[k] <= frac_step(r_dv_fx[k-1],
                                        (k == 1) ? r_dv_side[k-1].mx[0] : 1'b0,
                                        r_dv_rr[k-1]);
                r_dv_fy[k] <= frac_step(r_dv_fy[k-1],
                                        (k == 1) ? r_dv_side[k-1].my[0] : 1'b0,
                                        r_dv_rr[k-1]);
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                r_dv_fx[k] <= r_dv_fx[k-1];
                r_dv_fy[k] <= r_dv_fy[k-1];
            end
        end
    end

    // W stage is index 0 of the final root section
    logic        r_rs_v    [0:RS_STEPS];
    logic [33:0] r_rs_val  [0:RS_STEPS];
    t_sq         r_rs      [0:RS_STEPS];
    logic [31:0] r_rs_rr   [0:RS_STEPS];
    logic [16:0] r_rs_qx   [0:RS_STEPS];
    logic [16:0] r_rs_qy   [0:RS_STEPS];
    t_side       r_rs_side [0:RS_STEPS];

    logic [32:0] n_rad;

    always_comb begin
        if (r_dv_sat[DIV_STEPS]) begin
            n_rad = r_dv_dneg[DIV_STEPS] ? RAD_ONE : '0;
        end else begin
            n_rad = {1'b0, r_dv[DIV_STEPS].q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_v[0] <= 1'b0;
        end else begin
            r_rs_v[0] <= r_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs_val[0]  <= {1'b0, n_rad};
        r_rs[0]      <= '0;
        r_rs_rr[0]   <= r_dv_rr[DIV_STEPS];
        r_rs_qx[0]   <= r_dv_fx[DIV_STEPS].q;
        r_rs_qy[0]   <= r_dv_fy[DIV_STEPS].q;
        r_rs_side[0] <= r_dv_side[DIV_STEPS];
    end

    for (k = 1; k <= RS_STEPS; k++) begin : g_rs
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rs_v[k] <= 1'b0;
            end else begin
                r_rs_v[k] <= r_rs_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            r_rs[k]      <= sqrt_step(r_rs[k-1], r_rs_val[k-1][33:32]);
            r_rs_val[k]  <= {r_rs_val[k-1][31:0], 2'b00};
            r_rs_rr[k]   <= r_rs_rr[k-1];
            r_rs_qx[k]   <= r_rs_qx[k-1];
            r_rs_qy[k]   <= r_rs_qy[k-1];
            r_rs_side[k] <= r_rs_side[k-1];
        end
    end

    // output stage
    t_side              n_so;
    logic [16:0]        n_sin;
    logic signed [17:0] n_xf, n_yf;

    always_comb begin
        n_so = r_rs_side[RS_STEPS];
        if (n_so.inv) begin
            n_sin = '0;
            n_xf  = ONE_Q16;
            n_yf  = '0;
        end else begin
            n_sin = r_rs[RS_STEPS].root[16:0];
            if (r_rs_rr[RS_STEPS] == '0) begin
                n_xf = ONE_Q16;
                n_yf = '0;
            end else begin
                n_xf = n_so.nx ? -18'(r_rs_qx[RS_STEPS]) : 18'(r_rs_qx[RS_STEPS]);
                n_yf = n_so.ny ? -18'(r_rs_qy[RS_STEPS]) : 18'(r_rs_qy[RS_STEPS]);
            end
        end
    end

    logic r_o_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_rs_v[RS_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_sin_theta  <= n_sin;
        o_x_fraction <= n_xf;
        o_y_fraction <= n_yf;
        o_invalid    <= n_so.inv;
    end

    assign o_valid = r_o_v;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("request did not emerge after pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_a_v, LAT - 1))
        else $error("result without a matching request");

    a_invalid_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_sin_theta == '0 && o_x_fraction == ONE_Q16
                                 && o_y_fraction == '0)
        else $error("invalid result fields not fixed");

    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sin_theta <= 17'd65536)
        else $error("sin_theta out of range");

endmodule
